>>> sv/pie_pkg.sv
// package for the power iteration eigen engine
// holds widths, codes and fixed-point helpers; no dependencies
package pie_pkg;

  localparam int PIE_MAX_DIM = 16;

  // internal widths
  localparam int VEC_W  = 40;  // wide vector entries (A*v results)
  localparam int Z_W    = 18;  // normalized entries, magnitude <= 1.0
  localparam int S_W    = 31;  // scaled entries ahead of the norm
  localparam int ACC_W  = 64;
  localparam int DIVD_W = 56;  // dividend magnitude: vector entry << 16
  localparam int DIVS_W = 48;  // divisor magnitude

  localparam logic [1:0] OP_WRITE_MATRIX = 2'd0;
  localparam logic [1:0] OP_WRITE_VECTOR = 2'd1;
  localparam logic [1:0] OP_RUN          = 2'd2;

  localparam logic [1:0] REG_DIMENSION  = 2'd0;
  localparam logic [1:0] REG_MAX_ITER   = 2'd1;
  localparam logic [1:0] REG_TOLERANCE  = 2'd2;

  typedef enum logic [1:0] {
    ST_CONVERGED  = 2'd0,
    ST_LIMIT      = 2'd1,
    ST_ZERO_NORM  = 2'd2,
    ST_ZERO_EIGEN = 2'd3
  } status_t;

  // signed divide by 65536, truncating toward zero
  function automatic logic signed [ACC_W-1:0] trunc_q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ((v < 0) ? 64'sd65535 : 64'sd0);
    return t >>> 16;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> sv/power_iteration_eigen.sv
// power iteration engine for the dominant eigenvalue and eigenvector
// uses pie_pkg for widths, codes and fixed-point helpers
//
// channel   signals                                   direction  carries
// item      item_valid/item_ready + 4 fields          in         load or run request
// result    result_valid/result_ready + 6 fields      out        one eigenvector element
// config    cfg_we, cfg_index, cfg_data               in         register write, no wait
//
// load items (matrix or vector element) leave the engine idle, so they can follow back to back
// a run item is worked through serially: one shared multiplier does every product in turn,
// one shared restoring divider handles one element at a time, and the norm also needs
// an integer square root and a bit-by-bit scale search
// item_ready is low from run start until the last result transaction of that run
// no clearing pass after reset; result side stalls simply hold the current result
module power_iteration_eigen #(
  parameter int MAX_DIM = pie_pkg::PIE_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  row,
  input  logic [3:0]  column,
  input  logic signed [31:0] element_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [3:0]  index,
  output logic signed [31:0] vector_element,
  output logic signed [31:0] eigenvalue,
  output logic [15:0] iterations_done,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pie_pkg::*;

  localparam int LANES = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int LW    = $clog2(LANES);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LOAD   = 14'b00000000000010,
    S_NMAX   = 14'b00000000000100,
    S_NSHIFT = 14'b00000000001000,
    S_NSCALE = 14'b00000000010000,
    S_NSQRT  = 14'b00000000100000,
    S_NDIV   = 14'b00000001000000,
    S_MV     = 14'b00000010000000,
    S_DOT    = 14'b00000100000000,
    S_COPY   = 14'b00001000000000,
    S_CHECK  = 14'b00010000000000,
    S_FIN    = 14'b00100000000000,
    S_FDIV   = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  // where the run stands in the iteration
  typedef enum logic [3:0] {
    PH_INIT  = 4'b0001,  // normalizing the start vector
    PH_FIRST = 4'b0010,  // first estimate
    PH_LOOP  = 4'b0100,  // main loop, z = Ax/|Ax|
    PH_LOOP2 = 4'b1000   // main loop, x = Az and new estimate
  } phase_t;

  state_t  state;
  phase_t  phase;
  logic [1:0]    step;
  logic [LW-1:0] i, j, nlast;

  // configuration registers
  logic [4:0]  dimension;
  logic [15:0] max_iterations;
  logic [31:0] tolerance;

  // vector stores
  logic signed [31:0]      cv [LANES];
  logic signed [VEC_W-1:0] xv [LANES];
  logic signed [VEC_W-1:0] yv [LANES];
  logic signed [Z_W-1:0]   zv [LANES];

  // matrix memory
  logic signed [31:0] mat [DEPTH];
  logic signed [31:0] mrd;
  logic [AW-1:0] raddr, waddr;
  logic          mat_we;

  // arithmetic state
  logic signed [ACC_W-1:0] prod, acc, lam, nl;
  logic [VEC_W-1:0] mmax;
  logic [5:0]       shamt;
  logic             shdown;
  logic signed [S_W-1:0] sreg;
  logic [63:0] sq_v, sq_r, sq_bit;

  // shared divider
  logic [DIVD_W-1:0] dq;
  logic [DIVS_W:0]   drem;
  logic [DIVS_W-1:0] dden;
  logic [5:0]        dcnt;
  logic              dneg;

  logic [15:0]  iter;
  status_t      run_status;
  logic [31:0]  eig;

  // ---------------------------------------------------------------- datapath wires
  logic [LW-1:0] ridx;
  logic signed [31:0]      cr;
  logic signed [VEC_W-1:0] xr, yr;
  logic signed [Z_W-1:0]   zr;
  logic [VEC_W-1:0] ymag, xmag, smag;
  logic signed [VEC_W-1:0] scaled;
  logic signed [VEC_W-1:0] mul_a;
  logic signed [S_W-1:0]   mul_b;
  logic signed [VEC_W+S_W-1:0] mul_full;
  logic signed [ACC_W-1:0] sum, sum_q;
  logic [DIVS_W:0]   rsh;
  logic              dge;
  logic signed [DIVD_W:0] qs;
  logic [31:0]       qsat;
  logic [63:0]       sq_rb, nlmag, dmag;
  logic signed [ACC_W-1:0] dlam;
  logic [VEC_W-1:0]  mnext;
  logic              zero_out;
  logic [LW-1:0]     nlast_new;
  int                nclamp;

  assign item_ready = (state == S_IDLE);

  // the matrix-vector pass walks columns with j, everything else walks with i
  assign ridx = (state == S_MV) ? j : i;
  assign cr = cv[ridx];
  assign xr = xv[ridx];
  assign yr = yv[ridx];
  assign zr = zv[ridx];

  assign ymag = yr[VEC_W-1] ? VEC_W'(-yr) : VEC_W'(yr);
  assign xmag = xr[VEC_W-1] ? VEC_W'(-xr) : VEC_W'(xr);
  assign mnext = (ymag > mmax) ? ymag : mmax;

  // scale so the largest magnitude lies in [2^28, 2^29), truncating toward zero on the way down
  assign smag = ymag >> shamt;
  assign scaled = shdown ? (yr[VEC_W-1] ? -$signed(smag) : $signed(smag)) : (yr <<< shamt);

  // shared multiplier operand select
  always_comb begin
    mul_a = VEC_W'(sreg);
    mul_b = sreg;
    case (state)
      S_MV: begin
        mul_a = VEC_W'(mrd);
        mul_b = (phase == PH_LOOP2) ? S_W'(zr) : S_W'(xr);
      end
      S_DOT: begin
        mul_a = xr;
        mul_b = S_W'(zr);
      end
      default: begin
        mul_a = VEC_W'(sreg);
        mul_b = sreg;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  assign sum   = acc + prod;
  assign sum_q = trunc_q16(sum);

  // restoring divider step
  assign rsh = {drem[DIVS_W-1:0], dq[DIVD_W-1]};
  assign dge = (rsh >= {1'b0, dden});
  assign qs  = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  always_comb begin
    if (!dneg && dq > DIVD_W'(32'h7fff_ffff)) qsat = 32'h7fff_ffff;
    else if (dneg && dq > DIVD_W'(32'h8000_0000)) qsat = 32'h8000_0000;
    else qsat = qs[31:0];
  end

  assign sq_rb = sq_r + sq_bit;
  assign nlmag = nl[ACC_W-1] ? 64'(-nl) : 64'(nl);
  assign dlam  = nl - lam;
  assign dmag  = dlam[ACC_W-1] ? 64'(-dlam) : 64'(dlam);
  assign zero_out = (run_status == ST_ZERO_NORM) || (run_status == ST_ZERO_EIGEN);

  // dimension clamp: zero acts as one, large values as the lane count
  always_comb begin
    nclamp = int'(dimension);
    if (dimension == 5'd0) nclamp = 1;
    else if (int'(dimension) > LANES) nclamp = LANES;
    nlast_new = LW'(nclamp - 1);
  end

  // ---------------------------------------------------------------- matrix memory
  assign raddr  = AW'(int'(i) * MAX_DIM + int'(j));
  assign waddr  = AW'(int'(row) * MAX_DIM + int'(column));
  assign mat_we = item_valid && item_ready && (opcode == OP_WRITE_MATRIX) &&
                  (int'(row) < MAX_DIM) && (int'(column) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat[waddr] <= element_value;
    end
    mrd <= mat[raddr];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_INIT;
      step           <= 2'd0;
      i              <= '0;
      j              <= '0;
      nlast          <= '0;
      dimension      <= 5'd4;
      max_iterations <= 16'd1000;
      tolerance      <= 32'd7;
      result_valid   <= 1'b0;
      iter           <= '0;
      run_status     <= ST_CONVERGED;
      eig            <= '0;
    end else begin
      // configuration writes land whenever they come
      if (cfg_we) begin
        case (cfg_index)
          REG_DIMENSION: dimension      <= cfg_data[4:0];
          REG_MAX_ITER:  max_iterations <= cfg_data[15:0];
          REG_TOLERANCE: tolerance      <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (opcode)
              OP_WRITE_VECTOR: begin
                if (int'(row) < LANES) cv[LW'(row)] <= element_value;
              end
              OP_RUN: begin
                nlast      <= nlast_new;
                i          <= '0;
                phase      <= PH_INIT;
                iter       <= '0;
                run_status <= ST_CONVERGED;
                lam        <= '0;
                nl         <= '0;
                state      <= S_LOAD;
              end
              default: ;
            endcase
          end
        end

        S_LOAD: begin
          yv[i] <= VEC_W'(cr);
          if (i == nlast) begin
            i     <= '0;
            mmax  <= '0;
            state <= S_NMAX;
          end else begin
            i <= i + 1'b1;
          end
        end

        // largest magnitude
        S_NMAX: begin
          mmax <= mnext;
          if (i == nlast) begin
            i     <= '0;
            shamt <= '0;
            if (mnext == '0) begin
              run_status <= ST_ZERO_NORM;
              state      <= S_FIN;
            end else begin
              state <= S_NSHIFT;
            end
          end else begin
            i <= i + 1'b1;
          end
        end

        // one bit of scale per cycle
        S_NSHIFT: begin
          if (mmax[VEC_W-1:29] != '0) begin
            mmax   <= mmax >> 1;
            shamt  <= shamt + 1'b1;
            shdown <= 1'b1;
          end else if (mmax[28] == 1'b0) begin
            mmax   <= mmax << 1;
            shamt  <= shamt + 1'b1;
            shdown <= 1'b0;
          end else begin
            step  <= 2'd0;
            acc   <= '0;
            state <= S_NSCALE;
          end
          if (shamt == 6'd0 && mmax[VEC_W-1:28] == {{(VEC_W-29){1'b0}}, 1'b1}) begin
            shdown <= 1'b0;
          end
        end

        // scale each entry and sum its square
        S_NSCALE: begin
          case (step)
            2'd0: begin
              sreg  <= S_W'(scaled);
              yv[i] <= scaled;
              step  <= 2'd1;
            end
            2'd1: begin
              prod <= mul_full[ACC_W-1:0];
              step <= 2'd2;
            end
            default: begin
              step <= 2'd0;
              if (i == nlast) begin
                sq_v   <= 64'(sum);
                sq_r   <= '0;
                sq_bit <= 64'd1 << 62;
                i      <= '0;
                state  <= S_NSQRT;
              end else begin
                acc <= sum;
                i   <= i + 1'b1;
              end
            end
          endcase
        end

        // digit-by-digit integer square root
        S_NSQRT: begin
          if (sq_bit == '0) begin
            step  <= 2'd0;
            state <= S_NDIV;
          end else begin
            if (sq_v >= sq_rb) begin
              sq_v <= sq_v - sq_rb;
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end

        // z_i = s_i * 1.0 / norm
        S_NDIV: begin
          case (step)
            2'd0: begin
              dq   <= {ymag, 16'b0};
              drem <= '0;
              dden <= sq_r[DIVS_W-1:0];
              dneg <= yr[VEC_W-1];
              dcnt <= '0;
              step <= 2'd1;
            end
            2'd1: begin
              drem <= dge ? (rsh - {1'b0, dden}) : rsh;
              dq   <= {dq[DIVD_W-2:0], dge};
              dcnt <= dcnt + 1'b1;
              if (dcnt == 6'(DIVD_W - 1)) step <= 2'd2;
            end
            default: begin
              zv[i] <= Z_W'(qs);
              step  <= 2'd0;
              if (i == nlast) begin
                i   <= '0;
                j   <= '0;
                acc <= '0;
                case (phase)
                  PH_INIT: begin
                    phase <= PH_FIRST;
                    state <= S_COPY;
                  end
                  PH_FIRST: state <= S_DOT;
                  PH_LOOP: begin
                    phase <= PH_LOOP2;
                    state <= S_MV;
                  end
                  default: state <= S_FIN;
                endcase
              end else begin
                i <= i + 1'b1;
              end
            end
          endcase
        end

        // matrix times vector, one product at a time on the shared multiplier
        S_MV: begin
          case (step)
            2'd0: step <= 2'd1;
            2'd1: begin
              prod <= mul_full[ACC_W-1:0];
              step <= 2'd2;
            end
            default: begin
              step <= 2'd0;
              if (j == nlast) begin
                if (phase == PH_LOOP2) xv[i] <= VEC_W'(sum_q);
                else yv[i] <= VEC_W'(sum_q);
                acc <= '0;
                j   <= '0;
                if (i == nlast) begin
                  i    <= '0;
                  mmax <= '0;
                  state <= (phase == PH_LOOP2) ? S_DOT : S_NMAX;
                end else begin
                  i <= i + 1'b1;
                end
              end else begin
                acc <= sum;
                j   <= j + 1'b1;
              end
            end
          endcase
        end

        // x . z
        S_DOT: begin
          case (step)
            2'd0: step <= 2'd1;
            2'd1: begin
              prod <= mul_full[ACC_W-1:0];
              step <= 2'd2;
            end
            default: begin
              step <= 2'd0;
              if (i == nlast) begin
                i   <= '0;
                acc <= '0;
                if (phase == PH_LOOP2) begin
                  nl    <= sum_q;
                  iter  <= iter + 1'b1;
                  state <= S_CHECK;
                end else begin
                  lam   <= sum_q;
                  phase <= PH_LOOP;
                  state <= S_COPY;
                end
              end else begin
                acc <= sum;
                i   <= i + 1'b1;
              end
            end
          endcase
        end

        S_COPY: begin
          xv[i] <= VEC_W'(zr);
          if (i == nlast) begin
            i     <= '0;
            j     <= '0;
            step  <= 2'd0;
            acc   <= '0;
            state <= S_MV;
          end else begin
            i <= i + 1'b1;
          end
        end

        S_CHECK: begin
          if (dmag < {32'b0, tolerance}) begin
            run_status <= ST_CONVERGED;
            state      <= S_FIN;
          end else if (iter >= max_iterations) begin
            run_status <= ST_LIMIT;
            state      <= S_FIN;
          end else begin
            lam   <= nl;
            phase <= PH_LOOP;
            i     <= '0;
            state <= S_COPY;
          end
        end

        S_FIN: begin
          if (run_status == ST_ZERO_NORM) begin
            eig <= '0;
          end else if (nl == '0) begin
            run_status <= ST_ZERO_EIGEN;
            eig        <= '0;
          end else begin
            eig <= sat32(nl);
          end
          i     <= '0;
          step  <= 2'd0;
          state <= S_FDIV;
        end

        // x_i / lambda into the vector store, or zero after a zero norm or zero eigenvalue
        S_FDIV: begin
          case (step)
            2'd0: begin
              if (zero_out) begin
                cv[i] <= '0;
                if (i == nlast) begin
                  i     <= '0;
                  state <= S_EMIT;
                end else begin
                  i <= i + 1'b1;
                end
              end else begin
                dq   <= {xmag, 16'b0};
                drem <= '0;
                dden <= nlmag[DIVS_W-1:0];
                dneg <= xr[VEC_W-1] ^ nl[ACC_W-1];
                dcnt <= '0;
                step <= 2'd1;
              end
            end
            2'd1: begin
              drem <= dge ? (rsh - {1'b0, dden}) : rsh;
              dq   <= {dq[DIVD_W-2:0], dge};
              dcnt <= dcnt + 1'b1;
              if (dcnt == 6'(DIVD_W - 1)) step <= 2'd2;
            end
            default: begin
              cv[i] <= qsat;
              step  <= 2'd0;
              if (i == nlast) begin
                i     <= '0;
                state <= S_EMIT;
              end else begin
                i <= i + 1'b1;
              end
            end
          endcase
        end

        // one result transaction per element
        S_EMIT: begin
          if (!result_valid) begin
            index           <= 4'(i);
            vector_element  <= cr;
            eigenvalue      <= eig;
            iterations_done <= iter;
            status          <= run_status;
            last            <= (i == nlast);
            result_valid    <= 1'b1;
          end else if (result_ready) begin
            result_valid <= 1'b0;
            if (i == nlast) begin
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_result_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_EMIT))
    else $error("result valid outside emit");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input taken while result pending");

  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == S_NSQRT) |-> $onehot0(sq_bit))
    else $error("square root bit not one-hot");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (index == 4'(nlast)))
    else $error("last flag on wrong element");

endmodule
